[hdl/multilevel_priority_ready_queue_unit_assert.svh]
// Assertion macros for the multilevel priority ready queue unit.
`ifndef MULTILEVEL_PRIORITY_READY_QUEUE_UNIT_ASSERT_SVH
`define MULTILEVEL_PRIORITY_READY_QUEUE_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF

// Check a property at every rising edge outside reset.
`define MLPQ_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Check that a condition never holds at a rising edge outside reset.
`define MLPQ_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`else

`define MLPQ_ASSERT(label, clk, rst_n, prop, msg)
`define MLPQ_ASSERT_NEVER(label, clk, rst_n, cond, msg)

`endif

`endif

[hdl/mlpq_pkg.sv]
// Shared types and constants of the multilevel priority ready queue.
`default_nettype none

package mlpq_pkg;

    // Default sizing
    localparam int MAX_LEVELS_DEF  = 8;
    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int ID_BITS_DEF     = 8;

    // Default tag RAM geometry for the default sizing
    localparam int RAM_DEPTH_DEF = 2 * MAX_LEVELS_DEF * QUEUE_DEPTH_DEF;
    localparam int RAM_AW_DEF    = $clog2(RAM_DEPTH_DEF);

    // Configuration register indexes
    localparam logic [3:0] CFG_LEVEL_COUNT  = 4'd0;
    localparam logic [3:0] CFG_PREEMPT_MODE = 4'd1;

    // Configuration reset values
    localparam logic [3:0] LEVEL_COUNT_RST = 4'd4;

    // Operation codes
    localparam logic OP_ADD      = 1'b0;
    localparam logic OP_DISPATCH = 1'b1;

    // Tag RAM strobes
    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } ram_ctl_t;

endpackage

`default_nettype wire

[hdl/mlpq_tag_ram.sv]
// Single-port tag RAM holding every FIFO slot of both banks.
`default_nettype none

module mlpq_tag_ram #(
    parameter int DEPTH = mlpq_pkg::RAM_DEPTH_DEF,
    parameter int AW    = mlpq_pkg::RAM_AW_DEF,
    parameter int DW    = mlpq_pkg::ID_BITS_DEF
) (
    input  wire logic              clk,
    input  wire mlpq_pkg::ram_ctl_t ctl,
    input  wire logic [AW-1:0]     addr,
    input  wire logic [DW-1:0]     wdata,
    output logic      [DW-1:0]     rdata
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rdata_reg;

    // Write or read one slot per cycle; hold read data until the next read
    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[addr] <= wdata;
        end
        if (ctl.rd_en)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

[hdl/multilevel_priority_ready_queue_unit.sv]
// Top level of the two-bank multilevel priority ready queue.
`default_nettype none

// Ready queue with one FIFO of process tags per priority level in an active
// and an expired bank. On an add, the accept cycle decodes the level and bank;
// then S_ADD, once the output register is free, read-modify-writes the FIFO
// pointers, writes the tag RAM and loads the result. A dispatch walks the
// levels in use (min(level_count, MAX_LEVELS)) from the top down, one level
// per cycle through a single pointer read port, swapping banks when the active
// bank runs dry. The tag RAM has one port and a registered read, so a dispatch
// that finds an entry pops it in S_SCAN and posts the tag from S_DRAIN; one
// that finds both banks empty reports from S_SCAN. A stalled output holds the
// item in flight. No clearing pass runs after reset: only written slots are
// ever read.
// One item is in flight at a time; in_stall is high from accept until the
// result is loaded into the output register.
module multilevel_priority_ready_queue_unit #(
    parameter int MAX_LEVELS  = mlpq_pkg::MAX_LEVELS_DEF,
    parameter int QUEUE_DEPTH = mlpq_pkg::QUEUE_DEPTH_DEF,
    parameter int ID_BITS     = mlpq_pkg::ID_BITS_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    // Configuration write channel
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [3:0]        cfg_index,
    input  wire logic [3:0]        cfg_data,
    // Request channel
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic              op,
    input  wire logic [7:0]        proc_id,
    input  wire logic signed [3:0] dyn_prio,
    input  wire logic [3:0]        base_prio,
    // Result channel
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic [7:0]             out_id,
    output logic [2:0]             out_prio,
    output logic                   found,
    output logic                   preempt,
    output logic                   dropped
);

    localparam int NFIFO = 2 * MAX_LEVELS;
    localparam int LW    = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
    localparam int QW    = $clog2(NFIFO);
    localparam int DW    = $clog2(QUEUE_DEPTH);
    localparam int CW    = $clog2(QUEUE_DEPTH + 1);
    localparam int NW    = $clog2(MAX_LEVELS + 1);
    localparam int RDEP  = NFIFO * QUEUE_DEPTH;
    localparam int AW    = $clog2(RDEP);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_ADD   = 2'd1;
    localparam logic [1:0] S_SCAN  = 2'd2;
    localparam logic [1:0] S_DRAIN = 2'd3;

    // Control and configuration state
    logic [1:0]         state_reg, state_next;
    logic [3:0]         level_count_reg;
    logic               preempt_mode_reg;
    logic               active_bank_reg, active_bank_next;
    logic [2:0]         running_prio_reg, running_prio_next;
    logic               running_valid_reg, running_valid_next;
    logic [LW-1:0]      scan_lvl_reg, scan_lvl_next;
    logic               pass_reg, pass_next;

    // Latched add request
    logic [ID_BITS-1:0] id_reg, id_next;
    logic [QW-1:0]      add_q_reg, add_q_next;
    logic [3:0]         add_lvl_reg, add_lvl_next;
    logic               add_drop_reg, add_drop_next;

    // FIFO pointers
    logic [DW-1:0]      head_reg [NFIFO];
    logic [CW-1:0]      count_reg [NFIFO];

    // Output register
    logic               out_valid_reg, out_valid_next;
    logic [7:0]         out_id_reg, out_id_next;
    logic [2:0]         out_prio_reg, out_prio_next;
    logic               found_reg, found_next;
    logic               preempt_reg, preempt_next;
    logic               dropped_reg, dropped_next;

    // Datapath
    logic [NW-1:0]      n_use;
    logic [LW-1:0]      start_lvl;
    logic               in_fire;
    logic               slot_free;
    logic               acc_neg;
    logic [3:0]         acc_lvl;
    logic               acc_drop;
    logic               acc_bank;
    logic [LW-1:0]      acc_idx;
    logic [QW-1:0]      acc_q;
    logic [QW-1:0]      scan_q;
    logic [QW-1:0]      q_sel;
    logic [DW-1:0]      head_sel;
    logic [CW-1:0]      cnt_sel;
    logic [CW:0]        tail_sum;
    logic [DW-1:0]      tail;
    logic [CW:0]        head_inc;
    logic [DW-1:0]      head_wrap;
    logic               add_full;
    logic               add_fail;
    logic               hit;
    logic               fifo_upd;
    logic [DW-1:0]      head_upd;
    logic [CW-1:0]      cnt_upd;
    mlpq_pkg::ram_ctl_t ram_ctl;
    logic [AW-1:0]      ram_addr;
    logic [DW-1:0]      ram_slot;
    logic [ID_BITS-1:0] ram_rdata;

    // Effective level count and the top level of a scan
    assign n_use = ({28'd0, level_count_reg} > 32'(MAX_LEVELS)) ?
                   NW'(MAX_LEVELS) : NW'(level_count_reg);
    assign start_lvl = (n_use == '0) ? '0 : LW'(n_use - NW'(1));

    assign in_fire   = in_valid && !in_stall;
    assign slot_free = !out_valid_reg || !out_stall;

    // Decode an incoming add: refill exhausted priority into the expired bank
    assign acc_neg  = dyn_prio[3];
    assign acc_lvl  = acc_neg ? (base_prio - 4'd1) : $unsigned(dyn_prio);
    assign acc_drop = (acc_neg && (base_prio == 4'd0)) ||
                      (32'(acc_lvl) >= 32'(n_use));
    assign acc_bank = acc_neg ? !active_bank_reg : active_bank_reg;
    assign acc_idx  = LW'(acc_lvl);
    assign acc_q    = acc_bank ? (QW'(MAX_LEVELS) + QW'(acc_idx)) : QW'(acc_idx);

    // FIFO under scan in the active bank
    assign scan_q = active_bank_reg ? (QW'(MAX_LEVELS) + QW'(scan_lvl_reg)) :
                    QW'(scan_lvl_reg);
    assign q_sel  = (state_reg == S_ADD) ? add_q_reg : scan_q;

    // Pointer read port
    assign head_sel = head_reg[q_sel];
    assign cnt_sel  = count_reg[q_sel];

    // Tail slot wrapped with one compare and subtract; advanced head wraps to zero with one compare
    assign tail_sum  = (CW+1)'(head_sel) + (CW+1)'(cnt_sel);
    assign tail      = (tail_sum >= (CW+1)'(QUEUE_DEPTH)) ?
                       DW'(tail_sum - (CW+1)'(QUEUE_DEPTH)) : DW'(tail_sum);
    assign head_inc  = (CW+1)'(head_sel) + (CW+1)'(1);
    assign head_wrap = (head_inc >= (CW+1)'(QUEUE_DEPTH)) ? '0 : DW'(head_inc);

    assign add_full = (cnt_sel >= CW'(QUEUE_DEPTH));
    assign add_fail = add_drop_reg || add_full;
    assign hit      = (n_use != '0) && (cnt_sel != '0);

    // Tag RAM address: FIFO base plus slot
    assign ram_slot = (state_reg == S_ADD) ? tail : head_sel;
    assign ram_addr = AW'(q_sel) * AW'(QUEUE_DEPTH) + AW'(ram_slot);

    // Sequencer
    always_comb
    begin
        state_next         = state_reg;
        active_bank_next   = active_bank_reg;
        running_prio_next  = running_prio_reg;
        running_valid_next = running_valid_reg;
        scan_lvl_next      = scan_lvl_reg;
        pass_next          = pass_reg;
        id_next            = id_reg;
        add_q_next         = add_q_reg;
        add_lvl_next       = add_lvl_reg;
        add_drop_next      = add_drop_reg;
        out_valid_next     = out_valid_reg && out_stall;
        out_id_next        = out_id_reg;
        out_prio_next      = out_prio_reg;
        found_next         = found_reg;
        preempt_next       = preempt_reg;
        dropped_next       = dropped_reg;
        fifo_upd           = 1'b0;
        head_upd           = head_sel;
        cnt_upd            = cnt_sel;
        ram_ctl            = '0;

        case (state_reg)
            S_IDLE:
            begin
                // Latch the request beat
                if (in_fire)
                begin
                    id_next       = ID_BITS'(proc_id);
                    add_q_next    = acc_q;
                    add_lvl_next  = acc_lvl;
                    add_drop_next = acc_drop;
                    scan_lvl_next = start_lvl;
                    pass_next     = 1'b0;
                    state_next    = (op == mlpq_pkg::OP_DISPATCH) ? S_SCAN : S_ADD;
                end
            end
            S_ADD:
            begin
                // Push the tag and post the add result
                if (slot_free)
                begin
                    if (!add_fail)
                    begin
                        ram_ctl.wr_en = 1'b1;
                        fifo_upd      = 1'b1;
                        cnt_upd       = cnt_sel + CW'(1);
                    end
                    out_valid_next = 1'b1;
                    out_id_next    = 8'(id_reg);
                    out_prio_next  = add_fail ? 3'd0 : 3'(add_lvl_reg);
                    found_next     = 1'b0;
                    preempt_next   = !add_fail && preempt_mode_reg &&
                                     running_valid_reg &&
                                     ({1'b0, running_prio_reg} < add_lvl_reg);
                    dropped_next   = add_fail;
                    state_next     = S_IDLE;
                end
            end
            S_SCAN:
            begin
                if (hit)
                begin
                    // Pop the front tag and record the winner
                    ram_ctl.rd_en      = 1'b1;
                    fifo_upd           = 1'b1;
                    head_upd           = head_wrap;
                    cnt_upd            = cnt_sel - CW'(1);
                    running_prio_next  = 3'(scan_lvl_reg);
                    running_valid_next = 1'b1;
                    state_next         = S_DRAIN;
                end
                else if (scan_lvl_reg != '0)
                begin
                    scan_lvl_next = scan_lvl_reg - LW'(1);
                end
                else if (!pass_reg)
                begin
                    // Active bank dry: swap banks and search once more
                    active_bank_next = !active_bank_reg;
                    pass_next        = 1'b1;
                    scan_lvl_next    = start_lvl;
                end
                else if (slot_free)
                begin
                    // Both banks empty: report and drop the recorded entry
                    running_prio_next  = 3'd0;
                    running_valid_next = 1'b0;
                    out_valid_next     = 1'b1;
                    out_id_next        = 8'd0;
                    out_prio_next      = 3'd0;
                    found_next         = 1'b0;
                    preempt_next       = 1'b0;
                    dropped_next       = 1'b0;
                    state_next         = S_IDLE;
                end
            end
            S_DRAIN:
            begin
                // Post the popped tag once the output register frees up
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_id_next    = 8'(ram_rdata);
                    out_prio_next  = 3'(scan_lvl_reg);
                    found_next     = 1'b1;
                    preempt_next   = 1'b0;
                    dropped_next   = 1'b0;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            active_bank_reg   <= 1'b0;
            running_prio_reg  <= 3'd0;
            running_valid_reg <= 1'b0;
            scan_lvl_reg      <= '0;
            pass_reg          <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            active_bank_reg   <= active_bank_next;
            running_prio_reg  <= running_prio_next;
            running_valid_reg <= running_valid_next;
            scan_lvl_reg      <= scan_lvl_next;
            pass_reg          <= pass_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        id_reg       <= id_next;
        add_q_reg    <= add_q_next;
        add_lvl_reg  <= add_lvl_next;
        add_drop_reg <= add_drop_next;
        out_id_reg   <= out_id_next;
        out_prio_reg <= out_prio_next;
        found_reg    <= found_next;
        preempt_reg  <= preempt_next;
        dropped_reg  <= dropped_next;
    end

    // FIFO pointers: update the selected FIFO
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NFIFO; i++)
            begin
                head_reg[i]  <= '0;
                count_reg[i] <= '0;
            end
        end
        else if (fifo_upd)
        begin
            head_reg[q_sel]  <= head_upd;
            count_reg[q_sel] <= cnt_upd;
        end
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_count_reg  <= mlpq_pkg::LEVEL_COUNT_RST;
            preempt_mode_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                mlpq_pkg::CFG_LEVEL_COUNT:  level_count_reg  <= cfg_data;
                mlpq_pkg::CFG_PREEMPT_MODE: preempt_mode_reg <= cfg_data[0];
                default:                    ;
            endcase
        end
    end

    mlpq_tag_ram #(
        .DEPTH (RDEP),
        .AW    (AW),
        .DW    (ID_BITS)
    ) u_tag_ram (
        .clk   (clk),
        .ctl   (ram_ctl),
        .addr  (ram_addr),
        .wdata (id_reg),
        .rdata (ram_rdata)
    );

    assign cfg_ready = 1'b1;
    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_id    = out_id_reg;
    assign out_prio  = out_prio_reg;
    assign found     = found_reg;
    assign preempt   = preempt_reg;
    assign dropped   = dropped_reg;

`include "multilevel_priority_ready_queue_unit_assert.svh"

    `MLPQ_ASSERT(a_push_not_full, clk, rst_n, ram_ctl.wr_en |-> (cnt_sel < CW'(QUEUE_DEPTH)), "push into a full FIFO")
    `MLPQ_ASSERT(a_pop_records, clk, rst_n, ram_ctl.rd_en |=> (running_valid_reg && state_reg == S_DRAIN), "pop did not record the winner")
    `MLPQ_ASSERT(a_found_clean, clk, rst_n, (out_valid && found) |-> (!dropped && !preempt), "dispatch result flags add status")
    `MLPQ_ASSERT_NEVER(a_ram_one_port, clk, rst_n, ram_ctl.wr_en && ram_ctl.rd_en, "tag RAM read and write in one cycle")

endmodule

`default_nettype wire

[tb/sv/ready_queue_tracker_pkg.sv]
// Scoreboard class that predicts and checks the ready queue result beats.
package ready_queue_tracker_pkg;

    localparam int LEVELS = mlpq_pkg::MAX_LEVELS_DEF;
    localparam int DEPTH  = mlpq_pkg::QUEUE_DEPTH_DEF;

    // One result beat as the block presents it
    typedef struct packed {
        logic [7:0] tag;
        logic [2:0] level;
        logic       found;
        logic       preempt;
        logic       dropped;
    } queue_outcome_t;

    class ready_queue_tracker;

        // Mirror of both banks: FIFO number is bank * LEVELS + level
        logic [7:0]  slot_tag [2*LEVELS][DEPTH];
        int unsigned head [2*LEVELS];
        int unsigned fill [2*LEVELS];
        bit          active_bank;
        logic [2:0]  running_level;
        bit          running_set;

        // Register copies
        logic [3:0]  level_count;
        bit          preempt_enable;

        queue_outcome_t awaited [$];

        int mismatches;
        int checked;
        int served;
        int empties;
        int refused;
        int preemptions;

        function new();
            foreach (head[i])
            begin
                head[i] = 0;
                fill[i] = 0;
            end
            active_bank    = 1'b0;
            running_level  = '0;
            running_set    = 1'b0;
            level_count    = mlpq_pkg::LEVEL_COUNT_RST;
            preempt_enable = 1'b0;
            mismatches     = 0;
            checked        = 0;
            served         = 0;
            empties        = 0;
            refused        = 0;
            preemptions    = 0;
        endfunction

        // Track a register write; unknown indexes leave everything as it is
        function void write_register(logic [3:0] index, logic [3:0] data);
            if (index == mlpq_pkg::CFG_LEVEL_COUNT)
                level_count = data;
            else if (index == mlpq_pkg::CFG_PREEMPT_MODE)
                preempt_enable = data[0];
        endfunction

        function int levels_in_use();
            return (level_count > LEVELS) ? LEVELS : int'(level_count);
        endfunction

        // Pop the front of the highest non-empty visible level of one bank
        function bit take_head(bit bank, output logic [7:0] tag, output logic [2:0] level);
            int q;
            tag   = '0;
            level = '0;
            for (int i = levels_in_use() - 1; i >= 0; i--)
            begin
                q = bank * LEVELS + i;
                if (fill[q] > 0)
                begin
                    tag     = slot_tag[q][head[q]];
                    level   = 3'(i);
                    head[q] = (head[q] + 1) % DEPTH;
                    fill[q]--;
                    return 1'b1;
                end
            end
            return 1'b0;
        endfunction

        // Work out the result of one accepted request beat and queue it
        function void note_request(logic cmd, logic [7:0] tag, logic signed [3:0] dyn,
                                   logic [3:0] stat);
            queue_outcome_t r;
            int             lvl;
            bit             bank;
            int             q;
            logic [7:0]     got_tag;
            logic [2:0]     got_level;
            bit             ok;
            r = '0;
            if (cmd == mlpq_pkg::OP_ADD)
            begin
                r.tag = tag;
                // Exhausted quantum: refill from the static priority, park in expired bank
                if (dyn < 0)
                begin
                    lvl  = int'(stat) - 1;
                    bank = !active_bank;
                end
                else
                begin
                    lvl  = int'(dyn);
                    bank = active_bank;
                end
                if (lvl < 0 || lvl >= levels_in_use())
                    r.dropped = 1'b1;
                else
                begin
                    q = bank * LEVELS + lvl;
                    if (fill[q] >= DEPTH)
                        r.dropped = 1'b1;
                    else
                    begin
                        slot_tag[q][(head[q] + fill[q]) % DEPTH] = tag;
                        fill[q]++;
                        r.level   = 3'(lvl);
                        r.preempt = preempt_enable && running_set &&
                                    (running_level < 3'(lvl));
                    end
                end
                if (r.dropped)
                    refused++;
                if (r.preempt)
                    preemptions++;
            end
            else
            begin
                // Search active bank, swap once if it is dry
                ok = take_head(active_bank, got_tag, got_level);
                if (!ok)
                begin
                    active_bank = !active_bank;
                    ok = take_head(active_bank, got_tag, got_level);
                end
                if (ok)
                begin
                    r.found       = 1'b1;
                    r.tag         = got_tag;
                    r.level       = got_level;
                    running_level = got_level;
                    running_set   = 1'b1;
                    served++;
                end
                else
                begin
                    running_level = '0;
                    running_set   = 1'b0;
                    empties++;
                end
            end
            awaited = {awaited, r};
        endfunction

        // Compare one result beat with the oldest prediction
        function void check_result(queue_outcome_t seen);
            queue_outcome_t want;
            if (awaited.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: result beat with nothing pending: ", $time,
                             "id=%h prio=%0d found=%b preempt=%b dropped=%b",
                             seen.tag, seen.level, seen.found, seen.preempt,
                             seen.dropped);
                return;
            end
            want = awaited[0];
            awaited.delete(0);
            checked++;
            if (seen.tag !== want.tag || seen.level !== want.level ||
                seen.found !== want.found || seen.preempt !== want.preempt ||
                seen.dropped !== want.dropped)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: mismatch on beat %0d: ", $time, checked,
                             "expected id=%h prio=%0d found=%b preempt=%b dropped=%b, ",
                             want.tag, want.level, want.found, want.preempt,
                             want.dropped,
                             "got id=%h prio=%0d found=%b preempt=%b dropped=%b",
                             seen.tag, seen.level, seen.found, seen.preempt,
                             seen.dropped);
            end
        endfunction

        function int outstanding();
            return awaited.size();
        endfunction

    endclass

endpackage

[tb/sv/multilevel_priority_ready_queue_unit_test.sv]
// Top-level testbench of the multilevel priority ready queue unit.
module multilevel_priority_ready_queue_unit_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int               CYCLE_LIMIT      = 200000;
    localparam int               HOLD_OFF_CYCLES  = 300;
    localparam int               IDLE_PCT         = 35;
    localparam int               DRAIN_CYCLES     = 2 * mlpq_pkg::MAX_LEVELS_DEF + 6;
    localparam logic [3:0]       CFG_INDEX_UNUSED = 4'hF;
    localparam logic signed [3:0] DYN_EXHAUSTED   = -4'sd1;

    logic              clk;
    logic              rst_n;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [3:0]        cfg_index;
    logic [3:0]        cfg_data;
    logic              in_valid;
    logic              in_stall;
    logic              op;
    logic [7:0]        proc_id;
    logic signed [3:0] dyn_prio;
    logic [3:0]        base_prio;
    logic              out_valid;
    logic              out_stall;
    logic [7:0]        out_id;
    logic [2:0]        out_prio;
    logic              found;
    logic              preempt;
    logic              dropped;

    ready_queue_tracker_pkg::ready_queue_tracker tracker = new();

    bit calm_stretch;
    bit hold_request;
    bit hold_taken;
    int hold_left;
    int cycle_count;
    int sent;
    int setting_count;

    multilevel_priority_ready_queue_unit dut (.*);

    // Free-running clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Stop a hung run
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Timeout after %0d cycles with %0d results pending", cycle_count,
                 tracker.outstanding());
        $display("*** FAILED ***");
        $finish;
    end

    // Drive the result-side stall: random, calm, or one long hold-off
    initial
    begin
        out_stall  = 1'b0;
        hold_left  = 0;
        hold_taken = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else if (hold_request && !hold_taken)
            begin
                hold_taken = 1'b1;
                hold_left  = HOLD_OFF_CYCLES - 1;
                out_stall <= 1'b1;
            end
            else if (calm_stretch)
                out_stall <= 1'b0;
            else
                out_stall <= ($urandom_range(99) < IDLE_PCT);
        end
    end

    // Check every accepted result beat
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            tracker.check_result({out_id, out_prio, found, preempt, dropped});
    end

    // Offer one request beat, with a random gap first, and hold it until accepted
    task automatic send_request(logic cmd, logic [7:0] tag, logic signed [3:0] dyn,
                                logic [3:0] stat);
        int gap;
        gap = 0;
        if (!calm_stretch)
            while ($urandom_range(99) < IDLE_PCT)
                gap++;
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid  <= 1'b1;
        op        <= cmd;
        proc_id   <= tag;
        dyn_prio  <= dyn;
        base_prio <= stat;
        do
            @(posedge clk);
        while (in_stall);
        tracker.note_request(cmd, tag, dyn, stat);
        sent++;
    endtask

    // Drop the request valid and wait for every pending result
    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (tracker.outstanding() > 0)
            @(posedge clk);
    endtask

    task automatic write_register(logic [3:0] index, logic [3:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        tracker.write_register(index, data);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Write both registers once the block is idle; upper mode bits are don't-care
    task automatic apply_setting(logic [3:0] levels, bit mode);
        drain();
        write_register(mlpq_pkg::CFG_LEVEL_COUNT, levels);
        write_register(mlpq_pkg::CFG_PREEMPT_MODE, {3'($urandom_range(7)), mode});
        setting_count++;
    endtask

    // Mostly in-range levels, some exhausted quanta, some out-of-range levels
    task automatic random_request(int add_pct);
        int                span;
        int                pick;
        logic signed [3:0] dyn;
        logic [3:0]        stat;
        span = tracker.levels_in_use();
        if (span < 1)
            span = 1;
        pick = $urandom_range(99);
        if (pick < 20)
            dyn = DYN_EXHAUSTED;
        else if (pick < 30)
            dyn = 4'($urandom_range(7));
        else
            dyn = 4'($urandom_range(span - 1));
        if ($urandom_range(99) < 30)
            stat = 4'($urandom_range(8, 1));
        else
            stat = 4'($urandom_range(span, 1));
        send_request(($urandom_range(99) < add_pct) ? mlpq_pkg::OP_ADD :
                     mlpq_pkg::OP_DISPATCH, 8'($urandom), dyn, stat);
    endtask

    task automatic run_phase(logic [3:0] levels, bit mode, int add_pct, int items,
                             bit calm, bit squeeze);
        apply_setting(levels, mode);
        calm_stretch = calm;
        if (squeeze)
            hold_request = 1'b1;
        repeat (items) random_request(add_pct);
        calm_stretch = 1'b0;
    endtask

    initial
    begin
        rst_n     = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        in_valid  = 1'b0;
        op        = mlpq_pkg::OP_ADD;
        proc_id   = '0;
        dyn_prio  = '0;
        base_prio = 4'd1;
        sent          = 0;
        setting_count = 1;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset settings: empty dispatch, level bounds, refill into expired bank
        send_request(mlpq_pkg::OP_DISPATCH, 8'h00, 4'sd0, 4'd1);
        send_request(mlpq_pkg::OP_ADD, 8'hFF, 4'sd0, 4'd1);
        send_request(mlpq_pkg::OP_ADD, 8'h00, 4'sd3, 4'd1);
        send_request(mlpq_pkg::OP_ADD, 8'h5A, 4'sd4, 4'd1);
        send_request(mlpq_pkg::OP_ADD, 8'hA5, 4'sd7, 4'd1);
        send_request(mlpq_pkg::OP_ADD, 8'h3C, DYN_EXHAUSTED, 4'd8);
        send_request(mlpq_pkg::OP_ADD, 8'hC3, DYN_EXHAUSTED, 4'd1);
        send_request(mlpq_pkg::OP_ADD, 8'h81, DYN_EXHAUSTED, 4'd4);
        send_request(mlpq_pkg::OP_DISPATCH, 8'h11, 4'sd0, 4'd1);
        send_request(mlpq_pkg::OP_DISPATCH, 8'h22, 4'sd0, 4'd1);
        send_request(mlpq_pkg::OP_DISPATCH, 8'h44, 4'sd0, 4'd1);
        // Non-preemptive: running entry recorded, preempt stays low
        send_request(mlpq_pkg::OP_ADD, 8'h42, 4'sd2, 4'd3);

        // Preemptive, all levels: higher, equal and lower than running
        apply_setting(4'd8, 1'b1);
        send_request(mlpq_pkg::OP_ADD, 8'h77, 4'sd7, 4'd2);
        send_request(mlpq_pkg::OP_ADD, 8'h33, 4'sd3, 4'd2);
        send_request(mlpq_pkg::OP_ADD, 8'h19, 4'sd1, 4'd2);
        send_request(mlpq_pkg::OP_DISPATCH, 8'h00, 4'sd0, 4'd1);
        send_request(mlpq_pkg::OP_ADD, 8'h66, 4'sd6, 4'd7);

        // Lower the count: upper entries hide, empty dispatch clears running entry
        apply_setting(4'd2, 1'b1);
        send_request(mlpq_pkg::OP_DISPATCH, 8'h00, 4'sd0, 4'd1);
        send_request(mlpq_pkg::OP_DISPATCH, 8'h00, 4'sd0, 4'd1);
        send_request(mlpq_pkg::OP_DISPATCH, 8'h00, 4'sd0, 4'd1);
        send_request(mlpq_pkg::OP_ADD, 8'h01, 4'sd1, 4'd1);

        // Raise it again: hidden entries come back
        apply_setting(4'd8, 1'b1);
        send_request(mlpq_pkg::OP_DISPATCH, 8'h00, 4'sd0, 4'd1);
        send_request(mlpq_pkg::OP_DISPATCH, 8'h00, 4'sd0, 4'd1);

        // Unknown register index must be ignored; then no levels at all
        drain();
        write_register(CFG_INDEX_UNUSED, 4'($urandom));
        apply_setting(4'd0, 1'b0);
        send_request(mlpq_pkg::OP_ADD, 8'h80, 4'sd0, 4'd1);
        send_request(mlpq_pkg::OP_DISPATCH, 8'h00, 4'sd0, 4'd1);

        // Random phases: levels, mode, add percent, items, calm, hold-off
        run_phase(4'd8, 1'b1, 60, 200, 1'b0, 1'b0);
        run_phase(4'd1, 1'b0, 75, 120, 1'b0, 1'b0);
        run_phase(4'd2, 1'b1, 50, 150, 1'b0, 1'b0);
        run_phase(4'd15, 1'b1, 55, 200, 1'b1, 1'b0);
        run_phase(4'd0, 1'b0, 50, 40, 1'b0, 1'b0);
        run_phase(4'd5, 1'b0, 70, 150, 1'b0, 1'b1);
        drain();
        write_register(CFG_INDEX_UNUSED, 4'($urandom));
        run_phase(4'd8, 1'b1, 45, 300, 1'b0, 1'b0);

        // Let any stray beat show up before the verdict
        drain();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d requests over %0d register settings, ", sent, setting_count,
                 "with a %0d-cycle output hold-off.", HOLD_OFF_CYCLES);
        $display("Dispatches served %0d, empty %0d; ", tracker.served, tracker.empties,
                 "adds refused %0d; preemptions %0d; ", tracker.refused,
                 tracker.preemptions, "checked %0d, mismatches %0d.",
                 tracker.checked, tracker.mismatches);
        if (tracker.mismatches == 0 && tracker.outstanding() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

[files.f]
+incdir+hdl
hdl/mlpq_pkg.sv
hdl/mlpq_tag_ram.sv
hdl/multilevel_priority_ready_queue_unit.sv
tb/sv/ready_queue_tracker_pkg.sv
tb/sv/multilevel_priority_ready_queue_unit_test.sv
